@@ src/mps_pkg.sv @@
// shared constants and types for the masked pattern scanner
`default_nettype none
package mps_pkg;
	localparam int NUM_SLOTS_DEF   = 16;
	localparam int MAX_PATTERN_DEF = 32;
	localparam int POS_W           = 32;
	localparam int ID_W            = 32;
	localparam int LEN_W           = 6;
	localparam int CNT_W           = 5;
	localparam int OFS_W           = 64;

	typedef enum logic [1:0] {
		OP_SCAN   = 2'd0,
		OP_PBYTE  = 2'd1,
		OP_HEADER = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// control handed from the top level to every slot cell
	typedef struct packed {
		logic scan;
		logic clear;
		logic pbyte_we;
		logic hdr_we;
	} cell_ctl_t;
endpackage
`default_nettype wire

@@ src/mps_if.sv @@
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none
interface mps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [3:0]  slot;
	logic [4:0]  byte_index;
	logic [7:0]  pattern_byte;
	logic [7:0]  mask_byte;
	logic [31:0] signature_id;
	logic [5:0]  pattern_length;
	logic        is_pattern;
	logic [7:0]  scan_byte;
	logic        last_byte;
	logic [63:0] base_offset;
	modport source (output valid, operation, slot, byte_index, pattern_byte, mask_byte,
		signature_id, pattern_length, is_pattern, scan_byte, last_byte, base_offset,
		input ready);
	modport sink (input valid, operation, slot, byte_index, pattern_byte, mask_byte,
		signature_id, pattern_length, is_pattern, scan_byte, last_byte, base_offset,
		output ready);
endinterface

interface mps_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] hit_signature_id;
	logic [3:0]  hit_slot;
	logic [63:0] hit_offset;
	modport source (output valid, hit, hit_signature_id, hit_slot, hit_offset, input ready);
	modport sink (input valid, hit, hit_signature_id, hit_slot, hit_offset, output ready);
endinterface

interface mps_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/mps_window.sv @@
// shift line of the most recent scanned bytes
`default_nettype none
module mps_window #(
	parameter int MAX_PATTERN = mps_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mps_pkg::cell_ctl_t     ctl,
	input  wire logic [7:0]             byte_in,
	output logic [MAX_PATTERN-1:0][7:0] window
);
	import mps_pkg::*;
	logic [MAX_PATTERN-1:0][7:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.clear) begin
			win_q <= '0;
		end else if (ctl.scan) begin
			for (int i = MAX_PATTERN-1; i > 0; i--) win_q[i] <= win_q[i-1];
			win_q[0] <= byte_in;
		end
	end
	assign window = win_q;
endmodule
`default_nettype wire

@@ src/mps_cell.sv @@
// one signature slot: stored pattern, header and per-buffer match record
`default_nettype none
module mps_cell #(
	parameter int MAX_PATTERN = mps_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mps_pkg::cell_ctl_t              ctl,
	input  wire logic                            enabled,
	input  wire logic [$clog2(MAX_PATTERN)-1:0]  wr_index,
	input  wire logic [7:0]                      wr_data,
	input  wire logic [7:0]                      wr_mask,
	input  wire logic [mps_pkg::ID_W-1:0]        wr_id,
	input  wire logic [mps_pkg::LEN_W-1:0]       wr_len,
	input  wire logic                            wr_kind,
	input  wire logic [MAX_PATTERN-1:0][7:0]     window,
	input  wire logic [mps_pkg::POS_W-1:0]       next_pos,
	// chain: earlier cells that already hold a match pass their record on
	input  wire logic                            chain_hit_in,
	input  wire logic [mps_pkg::ID_W-1:0]        chain_id_in,
	input  wire logic [mps_pkg::POS_W-1:0]       chain_ofs_in,
	output logic                                 chain_hit_out,
	output logic [mps_pkg::ID_W-1:0]             chain_id_out,
	output logic [mps_pkg::POS_W-1:0]            chain_ofs_out,
	output logic                                 seen_now
);
	import mps_pkg::*;
	localparam int IW = $clog2(MAX_PATTERN);

	logic [MAX_PATTERN-1:0][7:0] data_q, mask_q;
	logic [ID_W-1:0]  id_q;
	logic [LEN_W-1:0] len_q;
	logic             kind_q;
	logic             seen_q;
	logic [POS_W-1:0] ofs_q;

	logic [MAX_PATTERN-1:0] byte_ok;
	logic                   all_ok;
	logic                   fire;
	logic [POS_W-1:0]       len_ext;

	assign len_ext = POS_W'(len_q);

	// pattern byte i lines up with window entry len-1-i
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < int'(len_q))
				byte_ok[i] = (window[IW'(int'(len_q) - 1 - i)] & mask_q[i]) == data_q[i];
			else
				byte_ok[i] = 1'b1;
		end
		all_ok = &byte_ok;
		fire = enabled && kind_q && !seen_q && (int'(len_q) <= MAX_PATTERN) &&
			((len_q == '0) || (next_pos >= len_ext && all_ok));
	end

	always_ff @(posedge clk) begin
		if (ctl.pbyte_we) begin
			data_q[wr_index] <= wr_data & wr_mask;
			mask_q[wr_index] <= wr_mask;
		end
		if (ctl.hdr_we) begin
			id_q   <= wr_id;
			len_q  <= wr_len;
			kind_q <= wr_kind;
		end
		if (ctl.scan && fire) ofs_q <= (len_q == '0) ? '0 : next_pos - len_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (ctl.clear) begin
			seen_q <= 1'b0;
		end else if (ctl.scan && fire) begin
			seen_q <= 1'b1;
		end
	end

	// on the last byte the record includes this byte's outcome
	assign seen_now      = (seen_q && enabled) || fire;
	assign chain_hit_out = chain_hit_in || seen_now;
	assign chain_id_out  = chain_hit_in ? chain_id_in : id_q;
	assign chain_ofs_out = chain_hit_in ? chain_ofs_in :
		(seen_q ? ofs_q : ((len_q == '0) ? '0 : next_pos - len_ext));
endmodule
`default_nettype wire

@@ src/masked_pattern_scanner.sv @@
// top level: request decode, slot cell chain and result register
`default_nettype none
// Masked byte-signature scanner. A scan byte is compared against all NUM_SLOTS
// slot cells at once, each cell matching its masked pattern against the shared
// byte window. The lowest matching slot is found by a priority chain running
// through the cells. A last byte yields one result held in an output register; a
// new request is taken while that register is empty or is being drained.
module masked_pattern_scanner #(
	parameter int NUM_SLOTS   = mps_pkg::NUM_SLOTS_DEF,
	parameter int MAX_PATTERN = mps_pkg::MAX_PATTERN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mps_in_if.sink   in_ch,
	mps_out_if.source out_ch,
	mps_cfg_if.sink  cfg
);
	import mps_pkg::*;
	localparam int IW = $clog2(MAX_PATTERN);

	logic [CNT_W-1:0] active_q;
	logic [POS_W-1:0] pos_q, next_pos;
	logic             out_valid_q;
	logic             out_hit_q;
	logic [ID_W-1:0]  out_id_q;
	logic [3:0]       out_slot_q;
	logic [OFS_W-1:0] out_ofs_q;

	logic      take;
	op_t       op;
	cell_ctl_t ctl;
	logic [MAX_PATTERN-1:0][7:0] window;
	logic [MAX_PATTERN-1:0][7:0] scan_win;
	logic      wr_ok_slot, wr_ok_idx;

	logic [NUM_SLOTS:0]              ch_hit;
	logic [NUM_SLOTS:0][ID_W-1:0]    ch_id;
	logic [NUM_SLOTS:0][POS_W-1:0]   ch_ofs;
	logic [NUM_SLOTS-1:0]            seen;
	logic [3:0]                      first_slot;

	assign cfg.ready    = 1'b1;
	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign take         = in_ch.valid && in_ch.ready;
	assign op           = op_t'(in_ch.operation);
	assign wr_ok_slot   = 32'(in_ch.slot) < 32'(NUM_SLOTS);
	assign wr_ok_idx    = 32'(in_ch.byte_index) < 32'(MAX_PATTERN);
	assign next_pos     = (pos_q == '1) ? pos_q : pos_q + 1'b1;

	always_comb begin
		ctl = '0;
		unique case (op)
			OP_SCAN: begin
				ctl.scan  = take;
				ctl.clear = take && in_ch.last_byte;
			end
			OP_PBYTE:  ctl.pbyte_we = take && wr_ok_slot && wr_ok_idx;
			OP_HEADER: ctl.hdr_we = take && wr_ok_slot;
			default: ctl = '0;
		endcase
	end

	mps_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .byte_in(in_ch.scan_byte), .window(window)
	);

	// cells compare against the window with the incoming byte already shifted in
	assign scan_win = {window[MAX_PATTERN-2:0], in_ch.scan_byte};

	assign ch_hit[0] = 1'b0;
	assign ch_id[0]  = '0;
	assign ch_ofs[0] = '0;

	for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_cell
		cell_ctl_t c;
		always_comb begin
			c = ctl;
			c.pbyte_we = ctl.pbyte_we && (32'(in_ch.slot) == s);
			c.hdr_we   = ctl.hdr_we && (32'(in_ch.slot) == s);
			// the clear applies after the final byte is scored
			c.scan     = ctl.scan && !ctl.clear;
		end
		mps_cell #(.MAX_PATTERN(MAX_PATTERN)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(c),
			.enabled(32'(active_q) > s),
			.wr_index(in_ch.byte_index[IW-1:0]), .wr_data(in_ch.pattern_byte),
			.wr_mask(in_ch.mask_byte), .wr_id(in_ch.signature_id),
			.wr_len(in_ch.pattern_length), .wr_kind(in_ch.is_pattern),
			.window(scan_win), .next_pos(next_pos),
			.chain_hit_in(ch_hit[s]), .chain_id_in(ch_id[s]), .chain_ofs_in(ch_ofs[s]),
			.chain_hit_out(ch_hit[s+1]), .chain_id_out(ch_id[s+1]),
			.chain_ofs_out(ch_ofs[s+1]), .seen_now(seen[s])
		);
	end

	// lowest slot whose record is set
	always_comb begin
		first_slot = '0;
		for (int s = NUM_SLOTS-1; s >= 0; s--)
			if (seen[s]) first_slot = 4'(s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) active_q <= cfg.data;
			out_valid_q <= ctl.clear ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_q);
			if (ctl.clear) begin
				pos_q <= '0;
			end else if (ctl.scan) begin
				pos_q <= next_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			out_hit_q  <= ch_hit[NUM_SLOTS];
			out_id_q   <= ch_hit[NUM_SLOTS] ? ch_id[NUM_SLOTS] : '0;
			out_slot_q <= ch_hit[NUM_SLOTS] ? first_slot : '0;
			out_ofs_q  <= ch_hit[NUM_SLOTS] ?
				in_ch.base_offset + OFS_W'(ch_ofs[NUM_SLOTS]) : '0;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.hit              = out_hit_q;
	assign out_ch.hit_signature_id = out_id_q;
	assign out_ch.hit_slot         = out_slot_q;
	assign out_ch.hit_offset       = out_ofs_q;

`ifndef NO_ASSERTIONS
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> pos_q == '0) else $error("position not cleared");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> out_valid_q) else $error("result lost");
	a_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_hit_q) |-> (out_id_q == '0 && out_ofs_q == '0))
		else $error("miss carries data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q) else $error("result dropped");
`endif
endmodule
`default_nettype wire
